// ===== src/fra_pkg.sv =====
// Shared widths, opcode codes and controller states for the fraction arithmetic core.
package fra_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;
	localparam int MAG_W         = 2 * OPERAND_WIDTH;
	localparam int RAW_W         = MAG_W + 1;
	localparam int RES_NUM_W     = 33;
	localparam int RES_DEN_W     = 32;
	localparam int MUL_CNT_W     = $clog2(OPERAND_WIDTH + 1);
	localparam int DIV_CNT_W     = $clog2(MAG_W + 1);
	localparam int SHIFT_W       = $clog2(MAG_W);

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_MAG,
		ST_GCD,
		ST_DIV,
		ST_DONE
	} fra_state_t;

endpackage

// ===== src/fra_mul.sv =====
// Bit-serial signed multiplier: shift-add over operand magnitudes, sign applied at the end.
module fra_mul (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] mcand,
	input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] mplr,
	output logic                                     done,
	output logic signed [fra_pkg::PROD_W-1:0]        prod
);
	import fra_pkg::*;

	logic [OPERAND_WIDTH-1:0] mcand_mag;
	logic [OPERAND_WIDTH-1:0] mplr_mag;
	logic [OPERAND_WIDTH-1:0] mag_q;
	logic [OPERAND_WIDTH-1:0] acc_q;
	logic [OPERAND_WIDTH-1:0] lo_q;
	logic [OPERAND_WIDTH:0]   sum;
	logic [PROD_W-1:0]        umag;
	logic                     neg_q;
	logic                     busy_q;
	logic                     done_q;
	logic [MUL_CNT_W-1:0]     cnt_q;
	logic signed [PROD_W-1:0] prod_q;

	assign mcand_mag = mcand[OPERAND_WIDTH-1] ? -mcand : mcand;
	assign mplr_mag  = mplr[OPERAND_WIDTH-1] ? -mplr : mplr;
	assign sum       = {1'b0, acc_q} + (lo_q[0] ? {1'b0, mag_q} : '0);
	assign umag      = {acc_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CNT_W'(OPERAND_WIDTH);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one multiplier bit per cycle; the final cycle applies the sign
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mcand_mag;
			lo_q  <= mplr_mag;
			acc_q <= '0;
			neg_q <= mcand[OPERAND_WIDTH-1] ^ mplr[OPERAND_WIDTH-1];
		end else if (busy_q && cnt_q != '0) begin
			acc_q <= sum[OPERAND_WIDTH:1];
			lo_q  <= {sum[0], lo_q[OPERAND_WIDTH-1:1]};
		end else if (busy_q) begin
			prod_q <= neg_q ? -umag : umag;
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

// ===== src/fra_gcd.sv =====
// Iterative binary GCD of two magnitudes, one reduction step per cycle.
module fra_gcd (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fra_pkg::MAG_W-1:0] a_in,
	input  logic [fra_pkg::MAG_W-1:0] b_in,
	output logic                      done,
	output logic [fra_pkg::MAG_W-1:0] gcd
);
	import fra_pkg::*;

	logic [MAG_W-1:0]   a_q;
	logic [MAG_W-1:0]   b_q;
	logic [MAG_W-1:0]   g_q;
	logic [SHIFT_W-1:0] sh_q;
	logic               busy_q;
	logic               back_q;
	logic               done_q;
	logic               zero_hit;
	logic               both_even;
	logic               a_gt_b;
	logic               reducing;
	logic               restoring;

	assign zero_hit  = (a_q == '0) || (b_q == '0);
	assign both_even = !a_q[0] && !b_q[0];
	assign a_gt_b    = a_q > b_q;
	assign reducing  = busy_q && !back_q;
	assign restoring = busy_q && back_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			back_q <= 1'b0;
			done_q <= 1'b0;
			sh_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				back_q <= 1'b0;
				sh_q   <= '0;
			end else if (reducing) begin
				if (zero_hit) begin
					back_q <= 1'b1;
				end else if (both_even) begin
					sh_q <= sh_q + 1'b1;
				end
			end else if (restoring) begin
				if (sh_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					sh_q <= sh_q - 1'b1;
				end
			end
		end
	end

	// strip twos, subtract the smaller odd value, then put the common twos back
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			b_q <= b_in;
		end else if (reducing) begin
			if (zero_hit) begin
				a_q <= a_q | b_q;
			end else if (both_even) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_gt_b) begin
				a_q <= b_q;
				b_q <= a_q - b_q;
			end else begin
				b_q <= b_q - a_q;
			end
		end else if (restoring) begin
			if (sh_q == '0) begin
				g_q <= a_q;
			end else begin
				a_q <= a_q << 1;
			end
		end
	end

	assign done = done_q;
	assign gcd  = g_q;

endmodule

// ===== src/fra_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fra_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [fra_pkg::MAG_W-1:0] dividend,
	input  logic [fra_pkg::MAG_W-1:0] divisor,
	output logic                      done,
	output logic [fra_pkg::MAG_W-1:0] quo
);
	import fra_pkg::*;

	logic [MAG_W-1:0]     rem_q;
	logic [MAG_W-1:0]     quo_q;
	logic [MAG_W-1:0]     dvs_q;
	logic [MAG_W:0]       trial;
	logic [MAG_W:0]       diff;
	logic                 ge;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== src/fraction_arith_reduce_core.sv =====
// Top level: signed fraction add/subtract/multiply/divide with GCD reduction.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  request | req_valid | req_stall | opcode, num_a, den_a, num_b, den_b
//  result  | rsp_valid | rsp_stall | res_num, res_den, status
//
// One item is in flight at a time. The three serial multipliers run side by side,
// the raw fraction is registered once all products are in, and ST_MAG takes the
// magnitudes and starts the binary GCD, which takes one step a cycle, data dependent.
// The two restoring dividers then run side by side, and ST_DONE hands off to the
// output register; a raw 0/0 skips the dividers. Reset clears control state only.
// req_stall is high while an item is in flight; a finished item waits until the
// output register is free, and the next request is taken while a result is held.
module fraction_arith_reduce_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     req_valid,
	output logic                                     req_stall,
	input  logic [1:0]                               opcode,
	input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] num_a,
	input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] den_a,
	input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] num_b,
	input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] den_b,
	output logic                                     rsp_valid,
	input  logic                                     rsp_stall,
	output logic signed [fra_pkg::RES_NUM_W-1:0]     res_num,
	output logic signed [fra_pkg::RES_DEN_W-1:0]     res_den,
	output logic                                     status
);
	import fra_pkg::*;

	fra_state_t state_q;
	fra_state_t state_d;

	// controller strobes
	logic mul_start;
	logic gcd_start;
	logic div_start;
	logic out_load;
	logic out_free;

	// request latch and multiplier operands
	opcode_t                         opcode_q;
	logic signed [OPERAND_WIDTH-1:0] mul0_b;

	// unit results
	logic                     mul0_done;
	logic                     mul1_done;
	logic                     mul2_done;
	logic                     mul_done;
	logic signed [PROD_W-1:0] p0;
	logic signed [PROD_W-1:0] p1;
	logic signed [PROD_W-1:0] p2;
	logic                     gcd_done;
	logic [MAG_W-1:0]         gcd_val;
	logic                     divn_done;
	logic                     divd_done;
	logic                     div_done;
	logic [MAG_W-1:0]         quo_num;
	logic [MAG_W-1:0]         quo_den;

	// raw fraction, magnitudes and signs
	logic signed [RAW_W-1:0] raw_num_d;
	logic signed [RAW_W-1:0] raw_den_d;
	logic signed [RAW_W-1:0] raw_num_q;
	logic signed [RAW_W-1:0] raw_den_q;
	logic [MAG_W-1:0]        mag_num_d;
	logic [MAG_W-1:0]        mag_den_d;
	logic [MAG_W-1:0]        mag_num_q;
	logic [MAG_W-1:0]        mag_den_q;
	logic                    neg_num_q;
	logic                    neg_den_q;

	// reduced result before the output register
	logic signed [RAW_W-1:0] qn_ext;
	logic signed [RAW_W-1:0] qd_ext;
	logic signed [RAW_W-1:0] fin_num_q;
	logic signed [RAW_W-1:0] fin_den_q;
	logic                    zero_q;

	// output register
	logic                        out_valid_q;
	logic signed [RES_NUM_W-1:0] res_num_q;
	logic signed [RES_DEN_W-1:0] res_den_q;
	logic                        status_q;

	// -------------------------------------------------------------------------
	// Cross products. mul0 forms num_a times den_b (or num_b for multiply),
	// mul1 forms num_b times den_a, mul2 forms den_a times den_b.
	// -------------------------------------------------------------------------
	assign mul0_b = (opcode_t'(opcode) == OP_MUL) ? num_b : den_b;

	fra_mul u_mul0 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (num_a),
		.mplr   (mul0_b),
		.done   (mul0_done),
		.prod   (p0)
	);

	fra_mul u_mul1 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (num_b),
		.mplr   (den_a),
		.done   (mul1_done),
		.prod   (p1)
	);

	fra_mul u_mul2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (den_a),
		.mplr   (den_b),
		.done   (mul2_done),
		.prod   (p2)
	);

	assign mul_done = mul0_done & mul1_done & mul2_done;

	// Combine the products into the raw numerator and denominator.
	always_comb begin
		raw_num_d = RAW_W'(p0);
		raw_den_d = RAW_W'(p2);
		case (opcode_q)
			OP_ADD: raw_num_d = RAW_W'(p0) + RAW_W'(p1);
			OP_SUB: raw_num_d = RAW_W'(p0) - RAW_W'(p1);
			OP_MUL: raw_num_d = RAW_W'(p0);
			OP_DIV: raw_den_d = RAW_W'(p1);
			default: raw_num_d = RAW_W'(p0);
		endcase
	end

	// Magnitudes feed the GCD; the signs ride alongside and come back at the end.
	assign mag_num_d = MAG_W'(raw_num_q[RAW_W-1] ? -raw_num_q : raw_num_q);
	assign mag_den_d = MAG_W'(raw_den_q[RAW_W-1] ? -raw_den_q : raw_den_q);

	fra_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a_in   (mag_num_d),
		.b_in   (mag_den_d),
		.done   (gcd_done),
		.gcd    (gcd_val)
	);

	// Both magnitudes divide exactly by the GCD; run the two lanes together.
	fra_div u_div_num (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_num_q),
		.divisor  (gcd_val),
		.done     (divn_done),
		.quo      (quo_num)
	);

	fra_div u_div_den (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_den_q),
		.divisor  (gcd_val),
		.done     (divd_done),
		.quo      (quo_den)
	);

	assign div_done = divn_done & divd_done;
	assign qn_ext   = {1'b0, quo_num};
	assign qd_ext   = {1'b0, quo_den};

	// -------------------------------------------------------------------------
	// Controller
	// -------------------------------------------------------------------------
	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mul_done) state_d = ST_MAG;
			end
			ST_MAG: begin
				state_d = ST_GCD;
			end
			ST_GCD: begin
				if (gcd_done) state_d = (gcd_val == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		mul_start = 1'b0;
		gcd_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				mul_start = req_valid;
			end
			ST_MAG: begin
				gcd_start = 1'b1;
			end
			ST_GCD: begin
				div_start = gcd_done && (gcd_val != '0);
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// -------------------------------------------------------------------------
	// Datapath registers
	// -------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		// hold the opcode for the combine step
		if (mul_start) begin
			opcode_q <= opcode_t'(opcode);
		end
		// capture the raw fraction once all products are in
		if (state_q == ST_MUL && mul_done) begin
			raw_num_q <= raw_num_d;
			raw_den_q <= raw_den_d;
		end
		if (gcd_start) begin
			mag_num_q <= mag_num_d;
			mag_den_q <= mag_den_d;
			neg_num_q <= raw_num_q[RAW_W-1];
			neg_den_q <= raw_den_q[RAW_W-1];
		end
		// a zero GCD means the raw result was 0/0: drop to zeros and flag it
		if (state_q == ST_GCD && gcd_done) begin
			zero_q    <= (gcd_val == '0);
			fin_num_q <= '0;
			fin_den_q <= '0;
		end
		// restore the signs on the reduced magnitudes
		if (state_q == ST_DIV && div_done) begin
			fin_num_q <= neg_num_q ? -qn_ext : qn_ext;
			fin_den_q <= neg_den_q ? -qd_ext : qd_ext;
		end
		if (out_load) begin
			res_num_q <= RES_NUM_W'(fin_num_q);
			res_den_q <= RES_DEN_W'(fin_den_q);
			status_q  <= zero_q;
		end
	end

	// Output register: load on hand-off, drop on a completed transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign status    = status_q;

endmodule
